// File: rtl/psgd_pkg.sv
`default_nettype none

package psgd_pkg;

  // command words passed from the parser to the register file side
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FRAME = 2'd2;
  localparam logic [1:0] CMD_END   = 2'd3;

  // input kinds carried on tuser
  localparam logic [1:0] FUNC_DATA  = 2'd0;
  localparam logic [1:0] FUNC_EOF   = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam logic [7:0] BYTE_FRAME = 8'hFF;
  localparam logic [7:0] BYTE_WAIT  = 8'hFE;
  localparam logic [7:0] BYTE_END   = 8'hFD;
  localparam logic [7:0] MAX_INDEX  = 8'h0F;
  localparam logic [4:0] HDR_SYNC   = 5'd4;
  localparam logic [4:0] HDR_LAST   = 5'd15;
  localparam logic [3:0] REG_SHAPE  = 4'd13;

  localparam int NUM_REGS     = 16;
  localparam int FIFO_DEPTH   = 4;
  localparam int HOLD_W       = 10;
  localparam int RESULT_W     = 93;
  localparam int OUT_TDATA_W  = 96;

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        index;
    logic [HOLD_W-1:0] data;
  } cmd_t;

  // first member sits in the highest bits, so hold_periods lands at bit 0
  typedef struct packed {
    logic              shape_retrigger;
    logic [3:0]        envelope_shape;
    logic [15:0]       envelope_period;
    logic [4:0]        level_c;
    logic [4:0]        level_b;
    logic [4:0]        level_a;
    logic [5:0]        mixer_flags;
    logic [4:0]        noise_period;
    logic [11:0]       tone_c;
    logic [11:0]       tone_b;
    logic [11:0]       tone_a;
    logic [HOLD_W-1:0] hold_periods;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/psgd_front.sv
`default_nettype none

module psgd_front
  import psgd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,
  input  wire logic [1:0] s_tuser,
  input  wire logic       full,
  output logic            push,
  output cmd_t            push_cmd
);

  localparam logic [1:0] PH_STOPPED = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_BODY    = 2'd2;
  localparam logic [1:0] PH_OPERAND = 2'd3;

  logic [1:0] phase, phase_next;
  logic [4:0] header_count, header_count_next;
  logic [3:0] pending_index, pending_index_next;
  logic       operand_is_count, operand_is_count_next;
  logic       accept;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    phase_next            = phase;
    header_count_next     = header_count;
    pending_index_next    = pending_index;
    operand_is_count_next = operand_is_count;
    push                  = 1'b0;
    push_cmd.kind         = CMD_START;
    push_cmd.index        = pending_index;
    push_cmd.data         = {{(HOLD_W-8){1'b0}}, s_tdata};
    if (accept) begin
      priority if (s_tuser == FUNC_START) begin
        phase_next            = PH_HEADER;
        header_count_next     = '0;
        pending_index_next    = '0;
        operand_is_count_next = 1'b0;
        push                  = 1'b1;
        push_cmd.kind         = CMD_START;
      end else if (s_tuser != FUNC_DATA && s_tuser != FUNC_EOF) begin
        push = 1'b0;
      end else if (phase == PH_STOPPED) begin
        push = 1'b0;
      end else if (s_tuser == FUNC_EOF) begin
        phase_next    = PH_STOPPED;
        push          = 1'b1;
        push_cmd.kind = CMD_END;
      end else begin
        unique case (phase)
          PH_HEADER: begin
            if (header_count == HDR_SYNC && s_tdata == BYTE_FRAME) begin
              // sync marker at header byte 4 doubles as the first frame end
              phase_next    = PH_BODY;
              push          = 1'b1;
              push_cmd.kind = CMD_FRAME;
              push_cmd.data = HOLD_W'(1);
            end else if (header_count >= HDR_LAST) begin
              phase_next = PH_BODY;
            end else begin
              header_count_next = header_count + 5'd1;
            end
          end
          PH_OPERAND: begin
            phase_next = PH_BODY;
            push       = 1'b1;
            if (operand_is_count) begin
              operand_is_count_next = 1'b0;
              push_cmd.kind         = CMD_FRAME;
              push_cmd.data         = (s_tdata == 8'd0) ? HOLD_W'(1)
                                                        : {s_tdata, 2'b00};
            end else begin
              push_cmd.kind = CMD_WRITE;
            end
          end
          default: begin
            priority if (s_tdata == BYTE_FRAME) begin
              push          = 1'b1;
              push_cmd.kind = CMD_FRAME;
              push_cmd.data = HOLD_W'(1);
            end else if (s_tdata == BYTE_END) begin
              phase_next    = PH_STOPPED;
              push          = 1'b1;
              push_cmd.kind = CMD_END;
            end else if (s_tdata == BYTE_WAIT) begin
              operand_is_count_next = 1'b1;
              phase_next            = PH_OPERAND;
            end else if (s_tdata <= MAX_INDEX) begin
              pending_index_next    = s_tdata[3:0];
              operand_is_count_next = 1'b0;
              phase_next            = PH_OPERAND;
            end else begin
              push = 1'b0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_STOPPED;
      header_count     <= '0;
      pending_index    <= '0;
      operand_is_count <= 1'b0;
    end else begin
      phase            <= phase_next;
      header_count     <= header_count_next;
      pending_index    <= pending_index_next;
      operand_is_count <= operand_is_count_next;
    end
  end

`ifndef ASSERT_OFF
  // a stopped parser only ever produces a restart
  a_stopped_quiet: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_STOPPED && push) |-> (push_cmd.kind == CMD_START))
    else $error("command issued while stopped");
`endif

endmodule

`default_nettype wire

// File: rtl/psgd_fifo.sv
`default_nettype none

module psgd_fifo
  import psgd_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// File: rtl/psgd_back.sv
`default_nettype none

module psgd_back
  import psgd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   empty,
  input  wire cmd_t                   cmd,
  output logic                        pop,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  logic [7:0] regs [NUM_REGS];
  logic       shape_written;
  logic       emits;
  result_t    frame, result;

  assign emits = (cmd.kind == CMD_FRAME) || (cmd.kind == CMD_END);
  assign pop   = !empty && (!emits || !m_tvalid || m_tready);

  always_comb begin
    frame.hold_periods    = cmd.data;
    frame.tone_a          = {regs[1][3:0], regs[0]};
    frame.tone_b          = {regs[3][3:0], regs[2]};
    frame.tone_c          = {regs[5][3:0], regs[4]};
    frame.noise_period    = regs[6][4:0];
    frame.mixer_flags     = regs[7][5:0];
    frame.level_a         = regs[8][4:0];
    frame.level_b         = regs[9][4:0];
    frame.level_c         = regs[10][4:0];
    frame.envelope_period = {regs[12], regs[11]};
    frame.envelope_shape  = regs[13][3:0];
    frame.shape_retrigger = shape_written && (regs[13] != BYTE_FRAME);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
      shape_written <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        unique case (cmd.kind)
          CMD_START: begin
            for (int i = 0; i < NUM_REGS; i++) begin
              regs[i] <= '0;
            end
            shape_written <= 1'b0;
          end
          CMD_WRITE: begin
            regs[cmd.index] <= cmd.data[7:0];
            if (cmd.index == REG_SHAPE) begin
              shape_written <= 1'b1;
            end
          end
          CMD_FRAME: begin
            result        <= frame;
            shape_written <= 1'b0;
            m_tvalid      <= 1'b1;
          end
          CMD_END: begin
            result   <= '0;
            m_tvalid <= 1'b1;
          end
        endcase
      end
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-RESULT_W){1'b0}}, result};

`ifndef ASSERT_OFF
  a_frame_hold: assert property (@(posedge clk) disable iff (rst)
    (pop && cmd.kind == CMD_FRAME) |=>
      (m_tvalid && m_tdata[HOLD_W-1:0] == $past(cmd.data) && $past(cmd.data) != '0))
    else $error("frame word lost or wrong hold");
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (pop && cmd.kind == CMD_END) |=> (m_tvalid && m_tdata == '0))
    else $error("stream end word not all zero");
`endif

endmodule

`default_nettype wire

// File: rtl/psg_frame_stream_decoder_unit.sv
`default_nettype none
// path: a byte that ends a frame or the stream is written into the command queue, then popped
// into the output register, which raises m_tvalid once the output register is free
// throughput: one byte per cycle; a stalled output is absorbed by the command queue
// of FIFO_DEPTH words between parser and register file, then s_tready drops
// reset: rst is synchronous; parser stopped, register file zero, queue and output empty

module psg_frame_stream_decoder_unit
  import psgd_pkg::*;
#(
  parameter int FIFO_DEPTH_P = FIFO_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,  // data_byte
  input  wire logic [1:0]             s_tuser,  // func
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // hold_periods, tone_a, tone_b, tone_c, noise_period, mixer_flags, level_a,
  // level_b, level_c, envelope_period, envelope_shape, shape_retrigger, zero pad
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  logic full, empty, push, pop;
  cmd_t push_cmd, pop_cmd;

  psgd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  psgd_fifo #(
    .DEPTH (FIFO_DEPTH_P)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  psgd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .cmd      (pop_cmd),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
